// File: sv/srcc_pkg.sv
// Package with shared types and constants for the segment versus box collision checker.
`default_nettype none
package srcc_pkg;
    localparam int MaxObstacles = 16;
    localparam int CoordBits    = 16;
    localparam int SlotBits     = 4;
    localparam int CountBits    = 5;
    localparam int SizeBits     = CoordBits - 1;
    localparam int DiffBits     = CoordBits + 1;
    localparam int SqBits       = 2 * CoordBits;
    localparam int ScaledBits   = 2 * DiffBits - 16 + 1;
    localparam int StepBits     = (ScaledBits + 1) / 2;
    localparam int ProdBits     = DiffBits + StepBits;
    localparam int QueueDepth   = 2;
    localparam int QueueIdxBits = 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [SizeBits-1:0]         w;
        logic [SizeBits-1:0]         h;
    } box_t;

    // One classified command passed from the front end to the back end.
    typedef struct packed {
        logic                        op;
        logic [SlotBits-1:0]         slot;
        box_t                        box;
        logic signed [CoordBits-1:0] fx;
        logic signed [CoordBits-1:0] fy;
        logic signed [CoordBits-1:0] tx;
        logic signed [CoordBits-1:0] ty;
    } cmd_t;
endpackage
`default_nettype wire

// File: sv/segment_rect_collision_check.sv
// Top level of the segment versus box collision checker.
//
// Channel  | Handshake             | Payload
// command  | start / busy          | operation, slot, box, segment endpoints
// config   | cfg_valid / cfg_ready | cfg_data (obstacle_count)
// result   | done strobe           | collision_free
//
// From an empty queue, a load passes the queue register and is written to the
// table when the back end pops it. A check strobes done early on a start or end
// point hit, after root extraction when shorter than one unit, and otherwise
// after setup and root extraction plus, per sample point, one multiply,
// 27 bit-serial divider steps and one test.
// Reset clears control state only; table slots are undefined until loaded.
// Busy rises while the two-entry command queue is full; results cannot be stalled.
`default_nettype none
module segment_rect_collision_check (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         operation,
    input  wire  [3:0]  slot,
    input  wire  signed [15:0] corner_x,
    input  wire  signed [15:0] corner_y,
    input  wire  [14:0] box_width,
    input  wire  [14:0] box_height,
    input  wire  signed [15:0] from_x,
    input  wire  signed [15:0] from_y,
    input  wire  signed [15:0] to_x,
    input  wire  signed [15:0] to_y,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data,
    output logic        done,
    output logic        collision_free
);
    import srcc_pkg::*;

    cmd_t                 in_cmd, head;
    logic                 full, not_empty, pop;
    logic [CountBits-1:0] count_reg;

    // Pack the command transaction.
    always_comb
    begin
        in_cmd.op    = operation;
        in_cmd.slot  = slot;
        in_cmd.box.x = corner_x;
        in_cmd.box.y = corner_y;
        in_cmd.box.w = box_width;
        in_cmd.box.h = box_height;
        in_cmd.fx    = from_x;
        in_cmd.fy    = from_y;
        in_cmd.tx    = to_x;
        in_cmd.ty    = to_y;
    end

    assign busy      = full;
    assign cfg_ready = 1'b1;

    // Obstacle count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    srcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !full),
        .push_cmd  (in_cmd),
        .full      (full),
        .pop       (pop),
        .head_cmd  (head),
        .not_empty (not_empty)
    );

    srcc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .obstacle_count (count_reg),
        .cmd            (head),
        .cmd_valid      (not_empty),
        .cmd_pop        (pop),
        .res_valid      (done),
        .res_free       (collision_free)
    );
endmodule
`default_nettype wire

// File: sv/srcc_front.sv
// Front end: command capture and a short command queue.
`default_nettype none
module srcc_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  srcc_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  wire                  pop,
    output srcc_pkg::cmd_t       head_cmd,
    output logic                 not_empty
);
    import srcc_pkg::*;

    cmd_t                  mem_reg [QueueDepth];
    logic [QueueIdxBits-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QueueIdxBits:0]   cnt_reg, cnt_next;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg + QueueIdxBits'(push);
        rptr_next = rptr_reg + QueueIdxBits'(pop);
        cnt_next  = cnt_reg + (QueueIdxBits+1)'(push) - (QueueIdxBits+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign head_cmd  = mem_reg[rptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (QueueIdxBits+1)'(QueueDepth));
endmodule
`default_nettype wire

// File: sv/srcc_back.sv
// Back end: obstacle table, step count and the point sampling walk.
`default_nettype none
module srcc_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [srcc_pkg::CountBits-1:0] obstacle_count,
    input  srcc_pkg::cmd_t            cmd,
    input  wire                       cmd_valid,
    output logic                      cmd_pop,
    output logic                      res_valid,
    output logic                      res_free
);
    import srcc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ENDS  = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_ROOT  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_TEST  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    box_t   table_reg [MaxObstacles];

    logic signed [CoordBits-1:0] fx_reg, fy_reg, tx_reg, ty_reg;
    logic signed [DiffBits-1:0]  dx_reg, dy_reg;
    logic [ScaledBits-1:0]       rem_reg;
    logic [StepBits-1:0]         root_reg, steps_reg, k_reg;
    logic [4:0]                  bitpos_reg;
    logic [ProdBits-1:0]         nx_reg, ny_reg, qx_reg, qy_reg;
    logic [ProdBits:0]           rx_reg, ry_reg;
    logic                        negx_reg, negy_reg;
    logic signed [CoordBits+1:0] px_reg, py_reg;
    logic                        endphase_reg;
    logic                        res_valid_reg, res_free_reg;

    // Hit test of one point against all active slots in parallel.
    logic                    hit;
    logic [CountBits-1:0]    active;
    always_comb
    begin
        active = (obstacle_count > CountBits'(MaxObstacles)) ?
                 CountBits'(MaxObstacles) : obstacle_count;
        hit = 1'b0;
        for (int i = 0; i < MaxObstacles; i++)
        begin
            if (CountBits'(i) < active &&
                px_reg >= (CoordBits+2)'(table_reg[i].x) &&
                px_reg <= (CoordBits+2)'(table_reg[i].x) +
                          (CoordBits+2)'($signed({1'b0, table_reg[i].w})) &&
                py_reg >= (CoordBits+2)'(table_reg[i].y) &&
                py_reg <= (CoordBits+2)'(table_reg[i].y) +
                          (CoordBits+2)'($signed({1'b0, table_reg[i].h})))
            begin
                hit = 1'b1;
            end
        end
    end

    // Square and root helpers.
    logic [DiffBits-1:0] ax, ay;
    logic [SqBits+1:0]   sq_sum;
    logic [ScaledBits-1:0] trial;
    logic [2*StepBits-1:0] root_sq;
    always_comb
    begin
        ax = dx_reg[DiffBits-1] ? DiffBits'(-dx_reg) : DiffBits'(dx_reg);
        ay = dy_reg[DiffBits-1] ? DiffBits'(-dy_reg) : DiffBits'(dy_reg);
        sq_sum = (SqBits+2)'(ax * ax) + (SqBits+2)'(ay * ay);
        root_sq = (2*StepBits)'((root_reg | (StepBits'(1) << bitpos_reg)) *
                                (root_reg | (StepBits'(1) << bitpos_reg)));
        trial = ScaledBits'(root_sq);
    end

    // Restoring division step for both axes.
    logic [ProdBits:0] rx_sh, ry_sh;
    always_comb
    begin
        rx_sh = {rx_reg[ProdBits-1:0], nx_reg[ProdBits-1]};
        ry_sh = {ry_reg[ProdBits-1:0], ny_reg[ProdBits-1]};
    end

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == OP_LOAD)
        begin
            table_reg[cmd.slot] <= cmd.box;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd_pop && cmd.op == OP_CHECK) state_next = S_ENDS;
            S_ENDS: if (hit || endphase_reg) state_next = hit ? S_IDLE : S_SQ;
            S_SQ:   state_next = S_ROOT;
            S_ROOT: if (bitpos_reg == 5'd0)
                        state_next = (root_next_zero()) ? S_IDLE : S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:  if (bitpos_reg == 5'd0) state_next = S_TEST;
            S_TEST: if (hit || k_reg == steps_reg) state_next = S_IDLE;
                    else state_next = S_MUL;
            default: state_next = S_IDLE;
        endcase
    end

    function automatic logic root_next_zero();
        logic [StepBits-1:0] r;
        begin
            r = (trial <= rem_reg) ? (root_reg | StepBits'(1)) : root_reg;
            return (r == '0);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            res_free_reg  <= 1'b0;
            endphase_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    endphase_reg <= 1'b0;
                end
                S_ENDS:
                begin
                    endphase_reg <= 1'b1;
                    if (hit)
                    begin
                        res_valid_reg <= 1'b1;
                        res_free_reg  <= 1'b0;
                    end
                end
                S_ROOT:
                begin
                    if (bitpos_reg == 5'd0 && root_next_zero())
                    begin
                        res_valid_reg <= 1'b1;
                        res_free_reg  <= 1'b1;
                    end
                end
                S_TEST:
                begin
                    if (hit)
                    begin
                        res_valid_reg <= 1'b1;
                        res_free_reg  <= 1'b0;
                    end
                    else if (k_reg == steps_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_free_reg  <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                fx_reg <= cmd.fx;
                fy_reg <= cmd.fy;
                tx_reg <= cmd.tx;
                ty_reg <= cmd.ty;
                dx_reg <= DiffBits'(cmd.tx) - DiffBits'(cmd.fx);
                dy_reg <= DiffBits'(cmd.ty) - DiffBits'(cmd.fy);
                px_reg <= (CoordBits+2)'(cmd.fx);
                py_reg <= (CoordBits+2)'(cmd.fy);
            end
            S_ENDS:
            begin
                px_reg <= (CoordBits+2)'(tx_reg);
                py_reg <= (CoordBits+2)'(ty_reg);
            end
            S_SQ:
            begin
                rem_reg    <= ScaledBits'(sq_sum >> 16);
                root_reg   <= '0;
                bitpos_reg <= 5'(StepBits - 1);
                k_reg      <= '0;
            end
            S_ROOT:
            begin
                if (trial <= rem_reg)
                begin
                    root_reg <= root_reg | (StepBits'(1) << bitpos_reg);
                    steps_reg <= root_reg | (StepBits'(1) << bitpos_reg);
                end
                else
                begin
                    steps_reg <= root_reg;
                end
                if (bitpos_reg != 5'd0)
                begin
                    bitpos_reg <= bitpos_reg - 5'd1;
                end
            end
            S_MUL:
            begin
                nx_reg <= ProdBits'(ax * (k_reg + StepBits'(1)));
                ny_reg <= ProdBits'(ay * (k_reg + StepBits'(1)));
                negx_reg <= dx_reg[DiffBits-1];
                negy_reg <= dy_reg[DiffBits-1];
                rx_reg <= '0;
                ry_reg <= '0;
                k_reg  <= k_reg + StepBits'(1);
                bitpos_reg <= 5'(ProdBits - 1);
            end
            S_DIV:
            begin
                if (rx_sh >= (ProdBits+1)'(steps_reg))
                begin
                    rx_reg <= rx_sh - (ProdBits+1)'(steps_reg);
                    qx_reg <= {qx_reg[ProdBits-2:0], 1'b1};
                end
                else
                begin
                    rx_reg <= rx_sh;
                    qx_reg <= {qx_reg[ProdBits-2:0], 1'b0};
                end
                if (ry_sh >= (ProdBits+1)'(steps_reg))
                begin
                    ry_reg <= ry_sh - (ProdBits+1)'(steps_reg);
                    qy_reg <= {qy_reg[ProdBits-2:0], 1'b1};
                end
                else
                begin
                    ry_reg <= ry_sh;
                    qy_reg <= {qy_reg[ProdBits-2:0], 1'b0};
                end
                nx_reg <= {nx_reg[ProdBits-2:0], 1'b0};
                ny_reg <= {ny_reg[ProdBits-2:0], 1'b0};
                if (bitpos_reg != 5'd0)
                begin
                    bitpos_reg <= bitpos_reg - 5'd1;
                end
                else
                begin
                    px_reg <= (CoordBits+2)'(fx_reg) + (negx_reg ?
                        -(CoordBits+2)'({qx_reg[ProdBits-2:0], rx_sh >= (ProdBits+1)'(steps_reg)}) :
                        (CoordBits+2)'({qx_reg[ProdBits-2:0], rx_sh >= (ProdBits+1)'(steps_reg)}));
                    py_reg <= (CoordBits+2)'(fy_reg) + (negy_reg ?
                        -(CoordBits+2)'({qy_reg[ProdBits-2:0], ry_sh >= (ProdBits+1)'(steps_reg)}) :
                        (CoordBits+2)'({qy_reg[ProdBits-2:0], ry_sh >= (ProdBits+1)'(steps_reg)}));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_free  = res_free_reg;
endmodule
`default_nettype wire

// File: tb/tb_segment_rect_collision_check.sv
// Self-checking testbench for the segment versus box collision checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_rect_collision_check;
    import srcc_pkg::*;

    localparam int WatchdogLimit = 60000;
    localparam int DrainCycles   = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic operation = OP_LOAD;
    logic [3:0] slot = '0;
    logic signed [15:0] corner_x = '0, corner_y = '0;
    logic [14:0] box_width = '0, box_height = '0;
    logic signed [15:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;
    logic done;
    logic collision_free;

    segment_rect_collision_check uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .slot(slot),
        .corner_x(corner_x), .corner_y(corner_y),
        .box_width(box_width), .box_height(box_height),
        .from_x(from_x), .from_y(from_y), .to_x(to_x), .to_y(to_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .collision_free(collision_free)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the obstacle table and the active count.
    box_t        shadow_box [MaxObstacles];
    logic [4:0]  shadow_count = '0;
    bit          expected_free_q [$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          checks_sent = 0;
    int          loads_sent = 0;
    int          blocked_seen = 0;
    int          idle_cycles = 0;

    // True when the point lies inside any active obstacle, bounds inclusive.
    function automatic bit point_blocked(longint px, longint py);
        int n;
        longint bx, by;
        n = (shadow_count > MaxObstacles) ? MaxObstacles : int'(shadow_count);
        for (int i = 0; i < n; i++)
        begin
            bx = shadow_box[i].x;
            by = shadow_box[i].y;
            if (px >= bx && px <= bx + longint'(shadow_box[i].w) &&
                py >= by && py <= by + longint'(shadow_box[i].h))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expected collision_free for a segment, sampled at whole-unit steps.
    function automatic bit segment_free(longint fx, longint fy, longint tx, longint ty);
        longint dx, dy, scaled, steps;
        dx = tx - fx;
        dy = ty - fy;
        if (point_blocked(fx, fy) || point_blocked(tx, ty))
            return 1'b0;
        scaled = (dx * dx + dy * dy) >>> 16;
        steps = 0;
        while ((steps + 1) * (steps + 1) <= scaled)
            steps++;
        for (longint k = 1; k <= steps; k++)
        begin
            if (point_blocked(fx + (dx * k) / steps, fy + (dy * k) / steps))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Drive one command and hold it until the block takes the transaction.
    task automatic send_command(logic op, logic [3:0] s, box_t b,
                                logic signed [15:0] fx, logic signed [15:0] fy,
                                logic signed [15:0] tx, logic signed [15:0] ty);
        operation  <= op;
        slot       <= s;
        corner_x   <= b.x;
        corner_y   <= b.y;
        box_width  <= b.w;
        box_height <= b.h;
        from_x     <= fx;
        from_y     <= fy;
        to_x       <= tx;
        to_y       <= ty;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (op == OP_LOAD)
        begin
            shadow_box[s] = b;
            loads_sent++;
        end
        else
        begin
            expected_free_q.push_back(segment_free(fx, fy, tx, ty));
            checks_sent++;
        end
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic load_slot(logic [3:0] s, box_t b);
        send_command(OP_LOAD, s, b, '0, '0, '0, '0);
    endtask

    task automatic check_segment(logic signed [15:0] fx, logic signed [15:0] fy,
                                 logic signed [15:0] tx, logic signed [15:0] ty);
        box_t b;
        b = '{x: 16'($urandom), y: 16'($urandom), w: 15'($urandom), h: 15'($urandom)};
        send_command(OP_CHECK, 4'($urandom), b, fx, fy, tx, ty);
    endtask

    // Wait for every outstanding result, then let a trailing load settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_free_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write obstacle_count; only called while the block is idle.
    task automatic write_count(logic [4:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow_count = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] near_coord(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic box_t random_box();
        box_t b;
        if ($urandom_range(99) < 15)
            b = '{x: 16'($urandom), y: 16'($urandom), w: 15'($urandom), h: 15'($urandom)};
        else
            b = '{x: near_coord(3000), y: near_coord(3000),
                  w: 15'($urandom_range(0, 1500)), h: 15'($urandom_range(0, 1500))};
        return b;
    endfunction

    task automatic random_check();
        logic signed [15:0] fx, fy;
        int r, span;
        r = $urandom_range(99);
        if (r < 2)
        begin
            check_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            return;
        end
        span = (r < 10) ? 8000 : 2048;
        fx = near_coord(4000);
        fy = near_coord(4000);
        check_segment(fx, fy, 16'(fx + near_coord(span)), 16'(fy + near_coord(span)));
    endtask

    // Empty table, extreme boxes, endpoint and midpoint hits, short segments.
    task automatic test_directed();
        sender_idle_pct = 0;
        check_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        wait_idle();
        load_slot(4'd0, '{x: 16'sh8000, y: 16'sh8000, w: 15'h7fff, h: 15'h7fff});
        load_slot(4'd15, '{x: 16'sh7fff, y: 16'sh7fff, w: 15'h0, h: 15'h0});
        load_slot(4'd1, '{x: 16'sd512, y: 16'sd512, w: 15'd256, h: 15'd256});
        for (int s = 2; s < 15; s++)
            load_slot(4'(s), '{x: 16'sd4000, y: 16'sd4000, w: 15'd10, h: 15'd10});
        wait_idle();
        write_count(5'd16);
        // Endpoint inside, on the edge, and the full-range diagonal.
        check_segment(16'sd600, 16'sd600, 16'sd2000, 16'sd100);
        check_segment(16'sd768, 16'sd768, 16'sd2000, 16'sd2000);
        check_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        // Segment crossing box 1 with both ends clear.
        check_segment(16'sd0, 16'sd640, 16'sd1500, 16'sd640);
        // Sample points along a row that no box covers.
        check_segment(16'sd0, 16'sd10, 16'sd3000, 16'sd10);
        // Short and zero-length segments test only the endpoints.
        check_segment(16'sd100, 16'sd100, 16'sd300, 16'sd100);
        check_segment(16'sd2000, 16'sd2000, 16'sd2000, 16'sd2000);
        check_segment(16'sd400, 16'sd640, 16'sd900, 16'sd640);
        // Single-point box at the top corner.
        check_segment(16'sh7f00, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        wait_idle();
        // A count above the table still tests all sixteen slots.
        write_count(5'd31);
        check_segment(16'sd600, 16'sd600, 16'sd700, 16'sd700);
        check_segment(16'sd0, 16'sd640, 16'sd1500, 16'sd640);
        wait_idle();
        write_count(5'd1);
        check_segment(16'sd0, 16'sd640, 16'sd1500, 16'sd640);
        check_segment(16'sh7f00, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        wait_idle();
    endtask

    // Random mix of loads and checks at one count and one sender idle rate.
    task automatic test_random_phase(logic [4:0] count, int idle_pct, int items);
        write_count(count);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(99) < 25)
                load_slot(4'($urandom), random_box());
            else
                random_check();
            if (i == items / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    // Compare each result with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_free_q.size() == 0)
            begin
                $error("collision_free: unexpected result %b", collision_free);
                error_count++;
            end
            else
            begin
                if (collision_free !== expected_free_q[0])
                begin
                    $error("collision_free: expected %b, actual %b",
                           expected_free_q[0], collision_free);
                    error_count++;
                end
                if (expected_free_q[0] == 1'b0)
                    blocked_seen++;
                void'(expected_free_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1 || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(5'd16, 0, 380);
        test_random_phase(5'd4, 65, 380);
        test_random_phase(5'd0, 36, 120);
        test_random_phase(5'd20, 36, 380);
        test_random_phase(5'd9, 0, 260);
        $display("Covered %0d loads and %0d checks (%0d blocked) over counts 0 to 31.",
                 loads_sent, checks_sent, blocked_seen);
        if (error_count == 0 && expected_free_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
sv/srcc_pkg.sv
sv/srcc_front.sv
sv/srcc_back.sv
sv/segment_rect_collision_check.sv
tb/tb_segment_rect_collision_check.sv
